>>> hdl/ids_pkg.sv
package ids_pkg;

  // opcode values on the request tuser
  localparam logic [1:0] OP_TRY_ADD  = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;

  localparam int unsigned MOUNT_W = 8;
  localparam int unsigned INODE_W = 64;
  localparam int unsigned KEY_W   = MOUNT_W + INODE_W;
  localparam int unsigned ENTRY_W = KEY_W + 1;
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned RES_W   = 8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic start;
    logic scan_en;
    logic res_load;
  } ids_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit_now;
    logic scan_last;
    logic out_busy;
  } ids_sts_t;

endpackage

>>> hdl/inflight_dedup_set.sv
// channel   dir  handshake                    tdata                        tuser
// s_axis    in   s_axis_tvalid/s_axis_tready  mount_id, inode_number       opcode
// m_axis    out  m_axis_tvalid/m_axis_tready  answer, stored, table_full   -
//
// a request scans the table from entry 0 until the first match or the last entry,
// and the next request is accepted only once its result is loaded; the table memory
// is read one entry a cycle, so a miss scans every entry and a hit stops at the match.
// after reset the table is cleared one entry a cycle, with tready low.
// a result waiting on m_axis_tready does not block accepting the next request,
// but that request's table update and result wait until the output register frees.
module inflight_dedup_set
  import ids_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [7:0] mount_id, [71:8] inode_number
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] answer, [1] stored, [2] table_full
);

  ids_cmd_t cmd;
  ids_sts_t sts;

  ids_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ids_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_op_i    (s_axis_tuser),
    .req_key_i   (s_axis_tdata),
    .res_ready_i (m_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_data_o  (m_axis_tdata)
  );

endmodule

>>> hdl/ids_ram.sv
module ids_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ids_datapath.sv
module ids_datapath
  import ids_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ids_cmd_t         cmd_i,
  output ids_sts_t         sts_o,
  input  logic [OPC_W-1:0] req_op_i,
  input  logic [KEY_W-1:0] req_key_i,
  input  logic             res_ready_i,
  output logic             res_valid_o,
  output logic [RES_W-1:0] res_data_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(TABLE_ENTRIES - 1);

  logic [CW-1:0]      addr_q, addr_d;
  logic [AW-1:0]      cmp_idx_q, cmp_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic               hit_q, hit_d;
  logic [AW-1:0]      hit_idx_q, hit_idx_d;
  logic               free_q, free_d;
  logic [AW-1:0]      free_idx_q, free_idx_d;
  logic [OPC_W-1:0]   op_q;
  logic [KEY_W-1:0]   key_q;
  logic               out_vld_q, out_vld_d;
  logic [2:0]         out_res_q;
  logic [2:0]         res_d;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic               rd_valid;
  logic               key_eq;
  logic               issue;
  logic               do_add;
  logic               do_remove;

  ids_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_valid = rdata[ENTRY_W-1];
  assign key_eq   = (rdata[KEY_W-1:0] == key_q);
  assign issue    = cmd_i.scan_en && (addr_q != CNT_END);

  assign sts_o.clr_last  = (addr_q == CNT_LAST);
  assign sts_o.hit_now   = cmd_i.scan_en && cmp_vld_q && rd_valid && key_eq;
  assign sts_o.scan_last = cmd_i.scan_en && cmp_vld_q && (cmp_idx_q == IDX_LAST);
  assign sts_o.out_busy  = out_vld_q && !res_ready_i;

  // decision on the finished scan
  assign do_add    = (op_q == OP_TRY_ADD) && !hit_q && free_q;
  assign do_remove = (op_q == OP_REMOVE) && hit_q;

  always_comb begin
    case (op_q)
      OP_TRY_ADD:  res_d = {!hit_q && !free_q, !hit_q && free_q, !hit_q};
      OP_REMOVE:   res_d = {1'b0, 1'b0, hit_q};
      OP_CONTAINS: res_d = {1'b0, 1'b0, hit_q};
      default:     res_d = 3'b000;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_q[AW-1:0];
    wdata = '0;
    if (cmd_i.clr_en) begin
      we = 1'b1;
    end else if (cmd_i.res_load) begin
      we    = do_add || do_remove;
      waddr = do_add ? free_idx_q : hit_idx_q;
      wdata = {do_add, key_q};
    end
  end

  always_comb begin
    addr_d     = addr_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (cmd_i.start) begin
      addr_d    = '0;
      cmp_vld_d = 1'b0;
      hit_d     = 1'b0;
      free_d    = 1'b0;
    end else if (cmd_i.clr_en) begin
      addr_d = addr_q + CW'(1);
    end else if (cmd_i.scan_en) begin
      cmp_vld_d = issue;
      if (issue) begin
        addr_d    = addr_q + CW'(1);
        cmp_idx_d = addr_q[AW-1:0];
      end
      if (sts_o.hit_now) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      // lowest free entry, kept for a try-add miss
      if (cmp_vld_q && !rd_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
  end

  assign out_vld_d = cmd_i.res_load ? 1'b1 : (res_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      addr_q    <= addr_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (cmd_i.start) begin
      op_q  <= req_op_i;
      key_q <= req_key_i;
    end
    if (cmd_i.res_load) begin
      out_res_q <= res_d;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_data_o  = {{(RES_W - 3){1'b0}}, out_res_q};

endmodule

>>> hdl/ids_ctrl.sv
module ids_ctrl
  import ids_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  ids_sts_t sts_i,
  output ids_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.hit_now || sts_i.scan_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // table update and result load go together, once
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/ids_checker.sv
module ids_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // one request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // stored and table_full only on a proceed answer, never together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!(m_axis_tdata[1] && m_axis_tdata[2]) &&
                       (!(m_axis_tdata[1] || m_axis_tdata[2]) || m_axis_tdata[0])))
    else $error("inconsistent result flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0))
    else $error("result padding not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind inflight_dedup_set ids_checker u_ids_checker (.*);

>>> sim/tb_inflight_dedup_set.sv
module tb_inflight_dedup_set;
  import ids_pkg::*;

  localparam int ENTRIES = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // a miss scans every entry; add headroom for receiver stalls and sender gaps
  localparam int LATENCY = ENTRIES + 3;
  localparam int STALL_LIMIT = 20 * LATENCY;

  typedef struct packed {
    logic table_full;
    logic stored;
    logic answer;
  } dedup_answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // [7:0] mount_id, [71:8] inode_number
  logic [1:0]  s_axis_tuser = '0;  // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [0] answer, [1] stored, [2] table_full

  // shadow copy of the key table
  logic        shadow_valid [ENTRIES];
  logic [7:0]  shadow_mount [ENTRIES];
  logic [63:0] shadow_inode [ENTRIES];

  dedup_answer_t pending_answers [$];
  logic [7:0]    key_mount [$];
  logic [63:0]   key_inode [$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  burst_left = 0;
  bit  sender_idles = 1'b1;
  int  rx_mode = 0;
  int  rx_run = 0;

  inflight_dedup_set #(
    .TABLE_ENTRIES(ENTRIES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // lookup, then update the shadow table the way the block does
  function automatic dedup_answer_t apply_to_shadow(logic [1:0] op, logic [7:0] mnt,
                                                    logic [63:0] ino);
    dedup_answer_t res;
    int hit;
    int free_slot;
    res = '0;
    hit = -1;
    free_slot = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_mount[i] == mnt && shadow_inode[i] == ino) hit = i;
      if (!shadow_valid[i]) free_slot = i;
    end
    case (op)
      OP_TRY_ADD: begin
        if (hit < 0) begin
          res.answer = 1'b1;
          if (free_slot >= 0) begin
            shadow_valid[free_slot] = 1'b1;
            shadow_mount[free_slot] = mnt;
            shadow_inode[free_slot] = ino;
            res.stored = 1'b1;
          end else begin
            res.table_full = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          res.answer = 1'b1;
        end
      end
      OP_CONTAINS: begin
        res.answer = (hit >= 0);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int shadow_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) n += int'(shadow_valid[i]);
    return n;
  endfunction

  function automatic logic [63:0] random_inode();
    return {$urandom, $urandom};
  endfunction

  task automatic sender_pause();
    int gap;
    if (!sender_idles) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 12);
    burst_left = $urandom_range(0, 10);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (gap - 1) @(negedge clk_i);
  endtask

  task automatic send_request(logic [1:0] op, logic [7:0] mnt, logic [63:0] ino);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {ino, mnt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_answers.push_back(apply_to_shadow(op, mnt, ino));
    sender_pause();
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // keys often share a mount or an inode with their neighbor to catch partial matches
  task automatic build_key_pool(int n);
    logic [7:0]  mnt;
    logic [63:0] ino;
    int          pick;
    key_mount.delete();
    key_inode.delete();
    for (int i = 0; i < n; i++) begin
      mnt = 8'($urandom_range(0, 255));
      ino = random_inode();
      pick = $urandom_range(0, 9);
      if (i > 0 && pick < 2) mnt = key_mount[i-1];
      else if (i > 0 && pick < 4) ino = key_inode[i-1];
      else if (pick == 4) ino = '0;
      else if (pick == 5) ino = '1;
      else if (pick == 6) mnt = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      key_mount.push_back(mnt);
      key_inode.push_back(ino);
    end
  endtask

  task automatic test_basic_ops();
    logic [63:0] ino_a;
    ino_a = random_inode();
    sender_idles = 1'b1;
    send_request(OP_CONTAINS, 8'h00, 64'h0);
    send_request(OP_REMOVE,   8'h00, 64'h0);
    send_request(OP_TRY_ADD,  8'h00, 64'h0);
    send_request(OP_TRY_ADD,  8'hff, '1);
    send_request(OP_TRY_ADD,  8'h00, 64'h0);
    send_request(OP_CONTAINS, 8'hff, '1);
    send_request(OP_CONTAINS, 8'hff, 64'h0);
    send_request(OP_CONTAINS, 8'h00, '1);
    send_request(OP_TRY_ADD,  8'h5a, ino_a);
    send_request(OP_TRY_ADD,  8'ha5, ino_a);
    send_request(OP_REMOVE,   8'h5a, ino_a ^ 64'h1);
    send_request(OP_REMOVE,   8'h00, 64'h0);
    send_request(OP_REMOVE,   8'h00, 64'h0);
    send_request(OP_CONTAINS, 8'h00, 64'h0);
    // freed lowest slot gets reused
    send_request(OP_TRY_ADD,  8'h01, 64'h8000_0000_0000_0000);
    send_request(OP_UNUSED,   8'hff, '1);
    send_request(OP_UNUSED,   8'h33, random_inode());
    send_request(OP_CONTAINS, 8'hff, '1);
    send_request(OP_REMOVE,   8'ha5, ino_a);
    send_request(OP_CONTAINS, 8'h5a, ino_a);
    send_request(OP_TRY_ADD,  8'ha5, ino_a);
  endtask

  task automatic test_full_table();
    logic [7:0]  mnt;
    logic [63:0] ino;
    sender_idles = 1'b1;
    while (shadow_count() < ENTRIES) begin
      send_request(OP_TRY_ADD, 8'($urandom_range(0, 255)), random_inode());
    end
    // try-add on a full table proceeds without storing
    send_request(OP_TRY_ADD, 8'h00, 64'h1234);
    send_request(OP_TRY_ADD, 8'hff, '1);
    send_request(OP_CONTAINS, 8'h00, 64'h1234);
    mnt = shadow_mount[ENTRIES/2];
    ino = shadow_inode[ENTRIES/2];
    send_request(OP_REMOVE, mnt, ino);
    send_request(OP_TRY_ADD, 8'h00, 64'h1234);
    send_request(OP_TRY_ADD, mnt, ino);
    for (int i = 0; i < ENTRIES; i += 3) begin
      send_request(OP_REMOVE, shadow_mount[i], shadow_inode[i]);
    end
  endtask

  task automatic test_drain_pause();
    sender_idles = 1'b0;
    send_request(OP_TRY_ADD, 8'h7e, random_inode());
    send_request(OP_CONTAINS, 8'h7e, 64'h0);
    wait_drain();
    send_request(OP_REMOVE, 8'h7e, 64'h0);
    sender_idles = 1'b1;
  endtask

  task automatic test_random_traffic(int n_req, int pool_n, int add_pct, int rem_pct,
                                     int con_pct, bit idles);
    logic [1:0]  op;
    logic [7:0]  mnt;
    logic [63:0] ino;
    int          r;
    int          k;
    sender_idles = idles;
    build_key_pool(pool_n);
    repeat (n_req) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) op = OP_TRY_ADD;
      else if (r < add_pct + rem_pct) op = OP_REMOVE;
      else if (r < add_pct + rem_pct + con_pct) op = OP_CONTAINS;
      else op = OP_UNUSED;
      if ($urandom_range(0, 19) == 0) begin
        mnt = 8'($urandom_range(0, 255));
        ino = random_inode();
      end else begin
        k = $urandom_range(0, pool_n - 1);
        mnt = key_mount[k];
        ino = key_inode[k];
      end
      if ($urandom_range(0, 149) == 0) wait_drain();
      send_request(op, mnt, ino);
    end
  endtask

  task automatic check_field(string name, logic [7:0] expv, logic [7:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    dedup_answer_t exp_ans;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        exp_ans = pending_answers.pop_front();
        check_field("answer",     8'(exp_ans.answer),     8'(m_axis_tdata[0]));
        check_field("stored",     8'(exp_ans.stored),     8'(m_axis_tdata[1]));
        check_field("table_full", 8'(exp_ans.table_full), 8'(m_axis_tdata[2]));
        check_field("padding",    8'h00,                  8'(m_axis_tdata[7:3]));
      end
    end
  end

  // receiver: long ready runs, random runs and hard stalls
  always @(negedge clk_i) begin
    if (rx_run == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_run = (rx_mode == 2) ? $urandom_range(1, 20) : $urandom_range(20, 200);
    end
    rx_run--;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_inflight_dedup_set: done, errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_mount[i] = '0;
      shadow_inode[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    test_full_table();
    test_drain_pause();
    test_random_traffic(500, 40,  45, 25, 25, 1'b1);
    test_random_traffic(500, 100, 70, 10, 15, 1'b1);
    test_random_traffic(400, 8,   40, 35, 20, 1'b1);
    test_random_traffic(400, 70,  50, 20, 25, 1'b0);
    test_random_traffic(200, 300, 80, 5,  10, 1'b1);

    wait_drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_inflight_dedup_set: done, clean");
    end else begin
      $display("tb_inflight_dedup_set: done, errors");
    end
    $finish;
  end

endmodule

>>> inflight_dedup_set.f
hdl/ids_pkg.sv
hdl/ids_ram.sv
hdl/ids_datapath.sv
hdl/ids_ctrl.sv
hdl/inflight_dedup_set.sv
hdl/ids_checker.sv
sim/tb_inflight_dedup_set.sv
